// ===== sv/rgb_gaussian_conv_5x5_macros.svh =====
// Assertion macros used by the control module of the filter
`ifndef RGB_GAUSSIAN_CONV_5X5_MACROS_SVH
`define RGB_GAUSSIAN_CONV_5X5_MACROS_SVH
// Check a consequence in the same cycle as its cause
`define RGBG_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Check a consequence in the cycle after its cause
`define RGBG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/rgbg_pkg.sv =====
// Shared constants, types and helpers of the 5x5 RGB filter
package rgbg_pkg;
  localparam int KSIZE          = 5;
  localparam int KCENTER        = 2;
  localparam int PIX_BITS       = 8;
  localparam int RGB_BITS       = 3 * PIX_BITS;
  localparam int GEOM_BITS      = 12;
  localparam int CFG_DATA_BITS  = 60;
  localparam int CFG_INDEX_BITS = 3;
  localparam int DIM_BITS       = 14;
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int DEF_COEF_BITS  = 12;
  localparam int SAT_MAX        = 255;

  localparam logic [GEOM_BITS-1:0] RESET_FRAME_WIDTH  = 12'd640;
  localparam logic [GEOM_BITS-1:0] RESET_FRAME_HEIGHT = 12'd480;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_KERNEL_ROW_0 = 3'd2,
    REG_KERNEL_ROW_1 = 3'd3,
    REG_KERNEL_ROW_2 = 3'd4,
    REG_KERNEL_ROW_3 = 3'd5,
    REG_KERNEL_ROW_4 = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } item_kind_e;

  // Control that travels with one column push down the pipe
  typedef struct packed {
    logic             push;
    logic             emit;
    logic             last;
    logic [KSIZE-1:0] row_ok;
    logic [KSIZE-1:0] col_ok;
  } tap_ctrl_t;

  // Zero counts as one, anything above the maximum as the maximum
  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [GEOM_BITS-1:0] v,
                                                    input int maxv);
    logic [DIM_BITS-1:0] r;
    if (v == '0) begin
      r = DIM_BITS'(1);
    end else if (int'(v) > maxv) begin
      r = DIM_BITS'(maxv);
    end else begin
      r = DIM_BITS'(v);
    end
    return r;
  endfunction
endpackage

// ===== sv/rgbg_if.sv =====
// Pixel input and result output channel interfaces
interface rgbg_pix_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [rgbg_pkg::PIX_BITS-1:0] red;
  logic [rgbg_pkg::PIX_BITS-1:0] green;
  logic [rgbg_pkg::PIX_BITS-1:0] blue;
  modport source (output valid, kind, red, green, blue, input ready);
  modport sink (input valid, kind, red, green, blue, output ready);
endinterface

interface rgbg_res_if;
  logic                          valid;
  logic                          ready;
  logic [rgbg_pkg::PIX_BITS-1:0] out_red;
  logic [rgbg_pkg::PIX_BITS-1:0] out_green;
  logic [rgbg_pkg::PIX_BITS-1:0] out_blue;
  logic                          frame_last;
  modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
  modport sink (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

// ===== sv/rgbg_ram.sv =====
// Generic single write port RAM with registered read
module rgbg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; a read of the written address returns the old word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ===== sv/rgbg_ctrl.sv =====
// Frame position counters, result scheduling and tap masks (stage 0)
`include "rgb_gaussian_conv_5x5_macros.svh"
module rgbg_ctrl #(
  parameter int MAX_WIDTH  = rgbg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgbg_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic                               in_kind,
  input  logic [rgbg_pkg::RGB_BITS-1:0]      in_rgb,
  output logic                               in_ready,
  input  logic [rgbg_pkg::GEOM_BITS-1:0]     frame_width,
  input  logic [rgbg_pkg::GEOM_BITS-1:0]     frame_height,
  output logic                               rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0]       rd_addr,
  output rgbg_pkg::tap_ctrl_t                s1_ctrl,
  output logic [$clog2(MAX_WIDTH)-1:0]       s1_col,
  output logic [rgbg_pkg::RGB_BITS-1:0]      s1_rgb
);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int DWID = $clog2(2 * MAX_WIDTH + 3);

  logic [WW-1:0]   cur_w;
  logic [HW-1:0]   cur_h;
  logic [CW-1:0]   in_col;
  logic [HW-1:0]   in_row;
  logic [CW-1:0]   out_col;
  logic [RW-1:0]   out_row;
  logic [CW-1:0]   pcol;
  logic [DWID-1:0] lead;

  logic [WW-1:0]   w_new, w;
  logic [HW-1:0]   h_new, h;
  logic [DWID-1:0] lead_max;
  logic            is_pix, start, in_done, pad_need, accept;
  logic            write, emit, push, at_last, frame_end;
  logic [rgbg_pkg::KSIZE-1:0] row_ok, col_ok;

  // Latch geometry on the first pixel of a frame
  always_comb begin
    is_pix   = (in_kind == rgbg_pkg::KIND_PIXEL);
    start    = in_valid && is_pix && in_col == '0 && in_row == '0 &&
               out_col == '0 && out_row == '0;
    w_new    = WW'(rgbg_pkg::clamp_dim(frame_width, MAX_WIDTH));
    h_new    = HW'(rgbg_pkg::clamp_dim(frame_height, MAX_HEIGHT));
    w        = start ? w_new : cur_w;
    h        = start ? h_new : cur_h;
    in_done  = (in_row >= h);
    lead_max = DWID'({w, 1'b0}) + DWID'(2);
    // Pad the tail of a tiny frame with pushes of no item
    pad_need = in_done && (lead < lead_max);
    in_ready = en && !pad_need;
    accept   = in_valid && in_ready;
    write    = accept && is_pix && !in_done;
    emit     = accept && (in_done || (write && lead >= lead_max));
    push     = (en && pad_need) || write || (accept && in_done);
    at_last  = (HW'(out_row) == h - HW'(1)) && (WW'(out_col) == w - WW'(1));
    frame_end = emit && at_last;
    rd_en    = push;
    rd_addr  = pcol;
  end

  // Mark the taps of the result's window that lie inside the frame
  always_comb begin
    for (int i = 0; i < rgbg_pkg::KSIZE; i++) begin
      if (i < rgbg_pkg::KCENTER) begin
        row_ok[i] = (out_row >= RW'(rgbg_pkg::KCENTER - i));
        col_ok[i] = (out_col >= CW'(rgbg_pkg::KCENTER - i));
      end else begin
        row_ok[i] = ((HW+1)'(out_row) + (HW+1)'(i - rgbg_pkg::KCENTER)) < (HW+1)'(h);
        col_ok[i] = ((WW+1)'(out_col) + (WW+1)'(i - rgbg_pkg::KCENTER)) < (WW+1)'(w);
      end
    end
  end

  // Advance the input, push and result positions
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_w   <= WW'(rgbg_pkg::clamp_dim(rgbg_pkg::RESET_FRAME_WIDTH, MAX_WIDTH));
      cur_h   <= HW'(rgbg_pkg::clamp_dim(rgbg_pkg::RESET_FRAME_HEIGHT, MAX_HEIGHT));
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      pcol    <= '0;
      lead    <= '0;
    end else begin
      if (accept && start) begin
        cur_w <= w_new;
        cur_h <= h_new;
      end
      if (write) begin
        if (WW'(in_col) + WW'(1) >= w) begin
          in_col <= '0;
          in_row <= in_row + HW'(1);
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
      // Clear the push position at frame end, else advance it
      if (frame_end) begin
        pcol <= '0;
        lead <= '0;
      end else begin
        if (push) begin
          if (WW'(pcol) + WW'(1) >= w) begin
            pcol <= '0;
          end else begin
            pcol <= pcol + CW'(1);
          end
        end
        lead <= lead + DWID'(push) - DWID'(emit);
      end
      if (emit) begin
        if (at_last) begin
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
        end else if (WW'(out_col) + WW'(1) >= w) begin
          out_col <= '0;
          out_row <= out_row + RW'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
    end
  end

  // Hand the push to stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl <= '0;
    end else if (en) begin
      s1_ctrl.push   <= push;
      s1_ctrl.emit   <= emit;
      s1_ctrl.last   <= frame_end;
      s1_ctrl.row_ok <= row_ok;
      s1_ctrl.col_ok <= col_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_col <= pcol;
      s1_rgb <= in_rgb;
    end
  end

  `RGBG_ASSERT(a_lead_bound, 1'b1, lead <= lead_max, "push lead past two rows and two pixels")
  `RGBG_ASSERT(a_row_in_frame, 1'b1, HW'(out_row) < cur_h, "result row outside the frame")
  `RGBG_ASSERT_NEXT(a_frame_wrap, frame_end, lead == '0 && pcol == '0 && in_row == '0, "frame end did not clear positions")
endmodule

// ===== sv/rgbg_linebuf.sv =====
// Four line stores and the 5x5 pixel window (stage 1)
module rgbg_linebuf #(
  parameter int MAX_WIDTH = rgbg_pkg::DEF_MAX_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]           rd_addr,
  input  rgbg_pkg::tap_ctrl_t                    s1_ctrl,
  input  logic [$clog2(MAX_WIDTH)-1:0]           s1_col,
  input  logic [rgbg_pkg::RGB_BITS-1:0]          s1_rgb,
  output rgbg_pkg::tap_ctrl_t                    s2_ctrl,
  output logic [rgbg_pkg::KSIZE-1:0][rgbg_pkg::KSIZE-1:0][rgbg_pkg::RGB_BITS-1:0] window
);
  localparam int LINES = rgbg_pkg::KSIZE - 1;
  localparam int LW    = LINES * rgbg_pkg::RGB_BITS;
  localparam int RB    = rgbg_pkg::RGB_BITS;

  logic [LW-1:0] rd_word, wr_word, lines, byp_word;
  logic          wr_en, byp;
  logic [rgbg_pkg::KSIZE-1:0][RB-1:0] column;

  // Each word holds one column of the four previous rows, newest lowest
  rgbg_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_lines (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_col),
    .wr_data (wr_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  // Forward a word written at the address read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (rd_en) begin
      byp <= wr_en && (s1_col == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_word <= wr_word;
    end
  end

  // Age every row by one line and form the new column
  always_comb begin
    wr_en   = en && s1_ctrl.push;
    lines   = byp ? byp_word : rd_word;
    wr_word = {lines[LW-RB-1:0], s1_rgb};
    column[rgbg_pkg::KSIZE-1] = s1_rgb;
    for (int i = 0; i < LINES; i++) begin
      column[i] = lines[(LINES-1-i)*RB +: RB];
    end
  end

  // Shift the window one column left per push
  always_ff @(posedge clk) begin
    if (en && s1_ctrl.push) begin
      for (int i = 0; i < rgbg_pkg::KSIZE; i++) begin
        for (int j = 0; j < rgbg_pkg::KSIZE - 1; j++) begin
          window[i][j] <= window[i][j+1];
        end
        window[i][rgbg_pkg::KSIZE-1] <= column[i];
      end
    end
  end

  // Pass on control of pushes that produce a result
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctrl <= '0;
    end else if (en) begin
      s2_ctrl <= s1_ctrl.emit ? s1_ctrl : '0;
    end
  end
endmodule

// ===== sv/rgbg_mac.sv =====
// Weighted sums, truncation and saturation (stages 2 to 4)
module rgbg_mac #(
  parameter int COEF_BITS = rgbg_pkg::DEF_COEF_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  rgbg_pkg::tap_ctrl_t                    s2_ctrl,
  input  logic [rgbg_pkg::KSIZE-1:0][rgbg_pkg::KSIZE-1:0][rgbg_pkg::RGB_BITS-1:0] window,
  input  logic [rgbg_pkg::KSIZE-1:0][rgbg_pkg::CFG_DATA_BITS-1:0] kernel,
  output logic                                   res_valid,
  output logic                                   res_last,
  output logic [rgbg_pkg::PIX_BITS-1:0]          res_red,
  output logic [rgbg_pkg::PIX_BITS-1:0]          res_green,
  output logic [rgbg_pkg::PIX_BITS-1:0]          res_blue
);
  localparam int K   = rgbg_pkg::KSIZE;
  localparam int PB  = rgbg_pkg::PIX_BITS;
  localparam int PW  = PB + COEF_BITS;
  localparam int RSW = PW + 3;
  localparam int TW  = PW + 5;
  localparam int SW  = TW - COEF_BITS;

  logic                            p_valid, p_last, r_valid, r_last;
  logic [2:0][K-1:0][K-1:0][PW-1:0] prod;
  logic [2:0][K-1:0][RSW-1:0]      rsum, rsum_next;
  logic [2:0][PB-1:0]              sat_next;
  logic [TW-1:0]                   total;
  logic [SW-1:0]                   shifted;

  // Multiply every in-frame tap by its weight, drop the others
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        for (int i = 0; i < K; i++) begin
          for (int j = 0; j < K; j++) begin
            if (s2_ctrl.row_ok[i] && s2_ctrl.col_ok[j]) begin
              prod[c][i][j] <= PW'(window[i][j][(2-c)*PB +: PB]) *
                               PW'(kernel[i][j*COEF_BITS +: COEF_BITS]);
            end else begin
              prod[c][i][j] <= '0;
            end
          end
        end
      end
    end
  end

  // Sum each kernel row
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < K; i++) begin
        rsum_next[c][i] = '0;
        for (int j = 0; j < K; j++) begin
          rsum_next[c][i] = rsum_next[c][i] + RSW'(prod[c][i][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsum <= rsum_next;
    end
  end

  // Sum the rows, drop the fraction and clip to the pixel range
  always_comb begin
    total   = '0;
    shifted = '0;
    for (int c = 0; c < 3; c++) begin
      total = '0;
      for (int i = 0; i < K; i++) begin
        total = total + TW'(rsum[c][i]);
      end
      shifted = total[TW-1:COEF_BITS];
      if (shifted > SW'(rgbg_pkg::SAT_MAX)) begin
        sat_next[c] = PB'(rgbg_pkg::SAT_MAX);
      end else begin
        sat_next[c] = shifted[PB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_red   <= sat_next[0];
      res_green <= sat_next[1];
      res_blue  <= sat_next[2];
      res_last  <= r_last;
      p_last    <= s2_ctrl.last;
      r_last    <= p_last;
    end
  end

  // Carry the valid bits along the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      r_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      p_valid   <= s2_ctrl.emit;
      r_valid   <= p_valid;
      res_valid <= r_valid;
    end
  end
endmodule

// ===== sv/rgb_gaussian_conv_5x5.sv =====
// 5x5 RGB convolution filter over a raster pixel stream, top level
//
// Pixels of a frame enter on pix in raster order (kind pixel); after the
// frame's last pixel, flush items (kind flush) drain the results still due.
// Each result leaves on res in raster order; frame_last marks the final one.
// The result for a pixel is produced by the input item that arrives two
// rows plus two pixels later, or by a flush, and reaches res through the
// stage 1, window, multiply, row-sum and output registers. One item is
// taken per cycle while pix.ready is high, set by the line store, which is
// read and written once per column push. For frames of fewer than two rows
// plus two pixels, pix.ready drops after the last pixel while the window is padded.
// The receiver may stall at will: while res holds an unaccepted result the
// whole pipe holds and pix.ready is low; nothing is dropped or repeated.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// Geometry is latched on a frame's first pixel, kernel writes act at once.
// Reset (rst, synchronous) clears positions and the pipe and restores
// 640x480 geometry and an all-zero kernel; the line store needs no clearing.
module rgb_gaussian_conv_5x5 #(
  parameter int MAX_WIDTH  = rgbg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgbg_pkg::DEF_MAX_HEIGHT,
  parameter int COEF_BITS  = rgbg_pkg::DEF_COEF_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  rgbg_pix_if.sink                            pix,
  rgbg_res_if.source                          res,
  input  logic                                cfg_write,
  input  logic [rgbg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rgbg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  localparam int CW = $clog2(MAX_WIDTH);

  logic [rgbg_pkg::GEOM_BITS-1:0] frame_width, frame_height;
  logic [rgbg_pkg::KSIZE-1:0][rgbg_pkg::CFG_DATA_BITS-1:0] kernel;
  logic                           en, rd_en;
  logic [CW-1:0]                  rd_addr, s1_col;
  logic [rgbg_pkg::RGB_BITS-1:0]  s1_rgb;
  rgbg_pkg::tap_ctrl_t            s1_ctrl, s2_ctrl;
  logic [rgbg_pkg::KSIZE-1:0][rgbg_pkg::KSIZE-1:0][rgbg_pkg::RGB_BITS-1:0] window;

  // Decode configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rgbg_pkg::RESET_FRAME_WIDTH;
      frame_height <= rgbg_pkg::RESET_FRAME_HEIGHT;
      kernel       <= '0;
    end else if (cfg_write) begin
      unique case (rgbg_pkg::cfg_reg_e'(cfg_index))
        rgbg_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[rgbg_pkg::GEOM_BITS-1:0];
        rgbg_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[rgbg_pkg::GEOM_BITS-1:0];
        rgbg_pkg::REG_KERNEL_ROW_0: kernel[0] <= cfg_data;
        rgbg_pkg::REG_KERNEL_ROW_1: kernel[1] <= cfg_data;
        rgbg_pkg::REG_KERNEL_ROW_2: kernel[2] <= cfg_data;
        rgbg_pkg::REG_KERNEL_ROW_3: kernel[3] <= cfg_data;
        rgbg_pkg::REG_KERNEL_ROW_4: kernel[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the whole pipe unless a result waits to be taken
  assign en = !res.valid || res.ready;

  rgbg_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (pix.valid),
    .in_kind      (pix.kind),
    .in_rgb       ({pix.red, pix.green, pix.blue}),
    .in_ready     (pix.ready),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .s1_ctrl      (s1_ctrl),
    .s1_col       (s1_col),
    .s1_rgb       (s1_rgb)
  );

  rgbg_linebuf #(.MAX_WIDTH(MAX_WIDTH)) u_linebuf (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .s1_ctrl (s1_ctrl),
    .s1_col  (s1_col),
    .s1_rgb  (s1_rgb),
    .s2_ctrl (s2_ctrl),
    .window  (window)
  );

  rgbg_mac #(.COEF_BITS(COEF_BITS)) u_mac (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .s2_ctrl   (s2_ctrl),
    .window    (window),
    .kernel    (kernel),
    .res_valid (res.valid),
    .res_last  (res.frame_last),
    .res_red   (res.out_red),
    .res_green (res.out_green),
    .res_blue  (res.out_blue)
  );
endmodule

// ===== tb/rgbg_tb_check.sv =====
// Checker of the 5x5 RGB filter: watches both channels, predicts and compares results
module rgbg_tb_check (
  input  logic                                clk,
  input  logic                                rst,
  rgbg_pix_if                                 pix,
  rgbg_res_if                                 res,
  input  logic                                cfg_write,
  input  logic [rgbg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rgbg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  fails,
  output int                                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = 4 * rgbg_pkg::DEF_MAX_WIDTH + 8;
  localparam int CB   = rgbg_pkg::DEF_COEF_BITS;

  typedef struct packed {
    logic [rgbg_pkg::PIX_BITS-1:0] r;
    logic [rgbg_pkg::PIX_BITS-1:0] g;
    logic [rgbg_pkg::PIX_BITS-1:0] b;
    logic                          last;
  } blur_px_t;

  blur_px_t                             blur_due_q[$];
  logic [rgbg_pkg::RGB_BITS-1:0]        ring_px [RING];
  logic [rgbg_pkg::GEOM_BITS-1:0]       reg_w, reg_h;
  logic [rgbg_pkg::CFG_DATA_BITS-1:0]   krow [rgbg_pkg::KSIZE];
  int unsigned                          icol, irow, ocol, orow, fw, fh;

  assign outstanding = blur_due_q.size();

  function automatic int unsigned limit_dim(input logic [rgbg_pkg::GEOM_BITS-1:0] v,
                                            input int unsigned m);
    if (v == 0) return 1;
    if (v > m) return m;
    return v;
  endfunction

  function automatic logic [rgbg_pkg::PIX_BITS-1:0] clip8(input logic [31:0] acc);
    logic [31:0] v;
    v = acc >> CB;
    return (v > rgbg_pkg::SAT_MAX) ? rgbg_pkg::PIX_BITS'(rgbg_pkg::SAT_MAX)
                                   : v[rgbg_pkg::PIX_BITS-1:0];
  endfunction

  // Convolve around the next output position, then advance it
  task automatic emit_blurred();
    logic [31:0]                   ar, ag, ab;
    logic [11:0]                   wt;
    logic [rgbg_pkg::RGB_BITS-1:0] p;
    int                            py, px;
    int unsigned                   q, total;
    blur_px_t                      o;
    ar = 0; ag = 0; ab = 0;
    total = fw * fh;
    q = orow * fw + ocol;
    for (int i = 0; i < rgbg_pkg::KSIZE; i++) begin
      py = int'(orow) + i - rgbg_pkg::KCENTER;
      if (py < 0 || py >= int'(fh)) continue;
      for (int j = 0; j < rgbg_pkg::KSIZE; j++) begin
        px = int'(ocol) + j - rgbg_pkg::KCENTER;
        if (px < 0 || px >= int'(fw)) continue;
        wt = krow[i][j*CB +: CB];
        p = ring_px[(int'(py) * fw + px) % RING];
        ar += p[23:16] * wt;
        ag += p[15:8] * wt;
        ab += p[7:0] * wt;
      end
    end
    o.r = clip8(ar);
    o.g = clip8(ag);
    o.b = clip8(ab);
    o.last = (q == total - 1);
    blur_due_q.push_back(o);
    if (o.last) begin
      icol = 0; irow = 0; ocol = 0; orow = 0;
    end else begin
      ocol++;
      if (ocol >= fw) begin
        ocol = 0;
        orow++;
      end
    end
  endtask

  // Advance the model by one accepted input item
  task automatic take_item(input logic kind, input logic [rgbg_pkg::RGB_BITS-1:0] rgb);
    logic        is_px, done;
    int unsigned total, q, p;
    is_px = (kind == rgbg_pkg::KIND_PIXEL);
    if (is_px && icol == 0 && irow == 0 && ocol == 0 && orow == 0) begin
      fw = limit_dim(reg_w, rgbg_pkg::DEF_MAX_WIDTH);
      fh = limit_dim(reg_h, rgbg_pkg::DEF_MAX_HEIGHT);
    end
    total = fw * fh;
    q = orow * fw + ocol;
    done = (irow >= fh);
    if (is_px && !done) begin
      p = irow * fw + icol;
      ring_px[p % RING] = rgb;
      icol++;
      if (icol >= fw) begin
        icol = 0;
        irow++;
      end
      if (p >= q + 2 * fw + 2) emit_blurred();
    end else if (done && q < total) begin
      emit_blurred();
    end
  endtask

  always @(posedge clk) begin
    blur_px_t got, want;
    if (rst) begin
      blur_due_q.delete();
      reg_w = rgbg_pkg::RESET_FRAME_WIDTH;
      reg_h = rgbg_pkg::RESET_FRAME_HEIGHT;
      for (int i = 0; i < rgbg_pkg::KSIZE; i++) krow[i] = '0;
      icol = 0; irow = 0; ocol = 0; orow = 0;
      fw = limit_dim(reg_w, rgbg_pkg::DEF_MAX_WIDTH);
      fh = limit_dim(reg_h, rgbg_pkg::DEF_MAX_HEIGHT);
      fails = 0;
    end else begin
      // Compare an accepted result with the oldest one due
      if (res.valid && res.ready) begin
        got = '{res.out_red, res.out_green, res.out_blue, res.frame_last};
        if (blur_due_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result r=%0d g=%0d b=%0d last=%0d",
                                    got.r, got.g, got.b, got.last);
        end else begin
          want = blur_due_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("result differs: want r=%0d g=%0d b=%0d last=%0d, got r=%0d g=%0d b=%0d last=%0d",
                       want.r, want.g, want.b, want.last, got.r, got.g, got.b, got.last);
          end
        end
      end
      if (pix.valid && pix.ready) take_item(pix.kind, {pix.red, pix.green, pix.blue});
      // Register writes, masked to the register widths
      if (cfg_write) begin
        case (cfg_index)
          rgbg_pkg::REG_FRAME_WIDTH:  reg_w = cfg_data[rgbg_pkg::GEOM_BITS-1:0];
          rgbg_pkg::REG_FRAME_HEIGHT: reg_h = cfg_data[rgbg_pkg::GEOM_BITS-1:0];
          rgbg_pkg::REG_KERNEL_ROW_0: krow[0] = cfg_data;
          rgbg_pkg::REG_KERNEL_ROW_1: krow[1] = cfg_data;
          rgbg_pkg::REG_KERNEL_ROW_2: krow[2] = cfg_data;
          rgbg_pkg::REG_KERNEL_ROW_3: krow[3] = cfg_data;
          rgbg_pkg::REG_KERNEL_ROW_4: krow[4] = cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/rgb_gaussian_conv_5x5_tb.sv =====
// Top of the 5x5 RGB filter testbench: clock, reset, stimulus and verdict
module rgb_gaussian_conv_5x5_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_write = 1'b0;
  logic [rgbg_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [rgbg_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
  int                                  fails, outstanding;
  int                                  send_idle = 0, recv_idle = 0;
  int                                  sent = 0;
  int                                  hold_left = 0;
  logic                                hold_req = 1'b0, hold_done = 1'b0;
  int unsigned                         eff_w = 640, eff_h = 480;

  rgbg_pix_if pix ();
  rgbg_res_if res ();

  rgb_gaussian_conv_5x5 dut (
    .clk(clk), .rst(rst), .pix(pix), .res(res),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rgbg_tb_check chk (
    .clk(clk), .rst(rst), .pix(pix), .res(res),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .outstanding(outstanding)
  );

  always #10 clk = ~clk;

  initial begin
    pix.valid = 1'b0;
    pix.kind = rgbg_pkg::KIND_PIXEL;
    pix.red = '0;
    pix.green = '0;
    pix.blue = '0;
    res.ready = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Offer one item, idling first at random, and hold it until taken
  task automatic push_item(input rgbg_pkg::item_kind_e k,
                           input logic [rgbg_pkg::RGB_BITS-1:0] rgb);
    while ($urandom_range(99) < send_idle) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.kind <= k;
    {pix.red, pix.green, pix.blue} <= rgb;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [rgbg_pkg::PIX_BITS-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return rgbg_pkg::PIX_BITS'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [rgbg_pkg::RGB_BITS-1:0] rand_rgb();
    return {rand_sample(), rand_sample(), rand_sample()};
  endfunction

  task automatic write_reg(input rgbg_pkg::cfg_reg_e idx,
                           input logic [rgbg_pkg::CFG_DATA_BITS-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Write raw geometry with random junk above bit 11; track what the block uses
  task automatic set_geom(input logic [rgbg_pkg::GEOM_BITS-1:0] w,
                          input logic [rgbg_pkg::GEOM_BITS-1:0] h);
    write_reg(rgbg_pkg::REG_FRAME_WIDTH, {$urandom(), 16'($urandom()), w});
    write_reg(rgbg_pkg::REG_FRAME_HEIGHT, {$urandom(), 16'($urandom()), h});
    eff_w = (w == 0) ? 1 : (w > rgbg_pkg::DEF_MAX_WIDTH) ? rgbg_pkg::DEF_MAX_WIDTH : w;
    eff_h = (h == 0) ? 1 : (h > rgbg_pkg::DEF_MAX_HEIGHT) ? rgbg_pkg::DEF_MAX_HEIGHT : h;
  endtask

  // Kernel styles: 0 zero, 1 all full scale, 2 centre tap only, 3 smooth, else raw random
  task automatic set_kernel(input int style);
    logic [rgbg_pkg::CFG_DATA_BITS-1:0] row;
    for (int i = 0; i < rgbg_pkg::KSIZE; i++) begin
      for (int j = 0; j < rgbg_pkg::KSIZE; j++) begin
        case (style)
          0: row[j*12 +: 12] = 12'd0;
          1: row[j*12 +: 12] = 12'hFFF;
          2: row[j*12 +: 12] = (i == rgbg_pkg::KCENTER && j == rgbg_pkg::KCENTER) ?
                               12'hFFF : 12'd0;
          3: row[j*12 +: 12] = 12'($urandom_range(330));
          default: row[j*12 +: 12] = 12'($urandom());
        endcase
      end
      write_reg(rgbg_pkg::cfg_reg_e'(rgbg_pkg::REG_KERNEL_ROW_0 + i), row);
    end
  endtask

  // Drop valid, wait for every due result, then let the pipe settle
  task automatic drain();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // One frame: pixels with stray early flushes, then the tail drained by
  // flushes and extra pixels, and sometimes an idle flush
  task automatic run_frame(input int early_pct, input int extra_pct);
    int unsigned total, pend;
    total = eff_w * eff_h;
    pend = (total < 2 * eff_w + 2) ? total : 2 * eff_w + 2;
    for (int unsigned p = 0; p < total; p++) begin
      if ($urandom_range(99) < early_pct) push_item(rgbg_pkg::KIND_FLUSH, rand_rgb());
      push_item(rgbg_pkg::KIND_PIXEL, rand_rgb());
    end
    for (int unsigned i = 0; i < pend; i++) begin
      if ($urandom_range(99) < extra_pct) push_item(rgbg_pkg::KIND_PIXEL, rand_rgb());
      else push_item(rgbg_pkg::KIND_FLUSH, rand_rgb());
    end
    if ($urandom_range(99) < 30) push_item(rgbg_pkg::KIND_FLUSH, rand_rgb());
    drain();
  endtask

  initial begin
    int target;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: tiny frame, full-scale centre tap, extreme samples
    set_geom(12'd3, 12'd2);
    set_kernel(2);
    end_writes();
    push_item(rgbg_pkg::KIND_FLUSH, 24'h000000);
    push_item(rgbg_pkg::KIND_PIXEL, 24'h000000);
    push_item(rgbg_pkg::KIND_PIXEL, 24'hFFFFFF);
    push_item(rgbg_pkg::KIND_FLUSH, 24'hFFFFFF);
    push_item(rgbg_pkg::KIND_PIXEL, 24'hFF00FF);
    push_item(rgbg_pkg::KIND_PIXEL, 24'h00FF00);
    push_item(rgbg_pkg::KIND_PIXEL, 24'h123456);
    push_item(rgbg_pkg::KIND_PIXEL, 24'hFFFFFF);
    push_item(rgbg_pkg::KIND_PIXEL, 24'hABCDEF);
    for (int i = 0; i < 5; i++) push_item(rgbg_pkg::KIND_FLUSH, 24'h000000);
    push_item(rgbg_pkg::KIND_FLUSH, 24'h000000);
    drain();
    // All full-scale kernel on a single pixel frame
    set_geom(12'd1, 12'd1);
    set_kernel(1);
    end_writes();
    push_item(rgbg_pkg::KIND_PIXEL, 24'hFFFFFF);
    push_item(rgbg_pkg::KIND_FLUSH, 24'h000000);
    drain();

    // Geometry out of range: width zero, then height zero
    set_geom(12'd0, 12'd5);
    set_kernel(3);
    end_writes();
    run_frame(1, 10);
    set_geom(12'd9, 12'd0);
    set_kernel(0);
    end_writes();
    run_frame(5, 20);

    // Random frames across the three idling phases
    target = sent + 1650;
    while (sent < target) begin
      if (sent < target - 1100) begin
        send_idle = 7;
        recv_idle = 84;
      end else if (sent < target - 550) begin
        send_idle = 84;
        recv_idle = 7;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (send_idle == 0 && !hold_done && !hold_req) begin
        set_geom(12'd12, 12'd6);
        hold_req <= 1'b1;
      end else if ($urandom_range(99) < 85) begin
        set_geom(12'($urandom_range(1, 10)), 12'($urandom_range(1, 6)));
      end else begin
        set_geom(12'($urandom_range(11, 40)), 12'($urandom_range(1, 3)));
      end
      if ($urandom_range(99) < 50) set_kernel($urandom_range(5));
      end_writes();
      run_frame(3, 15);
    end

    drain();
    repeat (20) @(posedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("rgb_gaussian_conv_5x5: match");
    end else begin
      $display("rgb_gaussian_conv_5x5: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("rgb_gaussian_conv_5x5: mismatch");
    $finish;
  end
endmodule
